// ----- rtl/core/point_segment_distance_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the point to segment distance unit
// Each macro checks one implication on the rising clock edge outside reset.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_UNIT_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/psd_pkg.sv -----
// ----------------------------------------------------------------------------
// psd_pkg
// Word types, widths and region codes of the point to segment distance unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

  localparam int CoordWidth = 32;
  localparam int DistWidth  = CoordWidth + 1;

  localparam logic [1:0] RegionDegenerate = 2'd0;
  localparam logic [1:0] RegionStart      = 2'd1;
  localparam logic [1:0] RegionEnd        = 2'd2;
  localparam logic [1:0] RegionInterior   = 2'd3;

  typedef struct packed {
    logic signed [CoordWidth-1:0] seg_start_x;
    logic signed [CoordWidth-1:0] seg_start_y;
    logic signed [CoordWidth-1:0] seg_end_x;
    logic signed [CoordWidth-1:0] seg_end_y;
    logic signed [CoordWidth-1:0] query_x;
    logic signed [CoordWidth-1:0] query_y;
  } in_word_t;

  typedef struct packed {
    logic [DistWidth-1:0] distance;
    logic [1:0]           nearest_region;
  } out_word_t;

endpackage

`default_nettype wire

// ----- rtl/core/point_segment_distance_unit.sv -----
// ----------------------------------------------------------------------------
// point_segment_distance_unit
// Exact distance from a query point to a 2D segment, floor of the root.
// Throughput: one word per cycle; the whole pipeline holds only while a
// finished result waits at the output and the sink stalls.
// Reset clears every valid bit at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "point_segment_distance_unit_assert.svh"

module point_segment_distance_unit
  import psd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  // Widths. Differences need one bit more than a coordinate, products twice
  // that. Squared lengths, the dot product and the cross product all have
  // magnitudes below 2^(2*CoordWidth+1), which sets MW.
  localparam int CW = CoordWidth;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int MW = 2 * CW + 1;
  localparam int NW = 2 * MW;
  localparam int K  = CW + 1;
  localparam int SW = DistWidth;

  // The pipeline advances as one whole unless the output holds a word that
  // the sink refuses.
  logic pipe_en;
  assign pipe_en    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !pipe_en;

  // Stage 1: differences d = b - a, w = p - a, e = p - b.
  logic signed [DW-1:0] s1_dx_q, s1_dy_q, s1_wx_q, s1_wy_q, s1_ex_q, s1_ey_q;
  // Stage 2: the ten products.
  logic signed [PW-1:0] s2_dxdx_q, s2_dydy_q, s2_wxdx_q, s2_wydy_q, s2_wxdy_q;
  logic signed [PW-1:0] s2_wydx_q, s2_wxwx_q, s2_wywy_q, s2_exex_q, s2_eyey_q;
  // Stage 3: squared length, dot, cross and the two end distances squared.
  logic signed [PW-1:0] s3_len2_q, s3_dot_q, s3_cr_q, s3_wsq_q, s3_esq_q;
  // Stage 4: region decision.
  logic [1:0]    s4_reg_q;
  logic [MW-1:0] s4_num_q, s4_den_q, s4_mag_q;
  // Stage 5: partial products of the squared cross product.
  logic [1:0]        s5_reg_q;
  logic [MW-1:0]     s5_num_q, s5_den_q;
  logic [2*CW-1:0]   s5_hh_q;
  logic [2*CW:0]     s5_hl_q;
  logic [2*CW+1:0]   s5_ll_q;

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;

  // Divider stages: index 0 holds the assembled dividend, each later stage
  // produces one quotient bit. The low register shifts dividend bits out and
  // quotient bits in, so it holds the quotient at the last stage.
  logic [MW-1:0] div_rem_q [0:MW];
  logic [MW-1:0] div_low_q [0:MW];
  logic [MW-1:0] div_den_q [0:MW];
  logic [1:0]    div_reg_q [0:MW];
  logic [MW:0]   div_v_q;

  // Square root stages, one root bit each.
  logic [SW:0]     sq_rem_q  [1:SW];
  logic [SW-1:0]   sq_root_q [1:SW];
  logic [2*SW-1:0] sq_x_q    [1:SW];
  logic [1:0]      sq_reg_q  [1:SW];
  logic [SW:1]     sq_v_q;

  logic [SW:0]     sq_rem_in  [0:SW-1];
  logic [SW-1:0]   sq_root_in [0:SW-1];
  logic [2*SW-1:0] sq_x_in    [0:SW-1];
  logic [1:0]      sq_reg_in  [0:SW-1];

  logic      out_valid_q;
  out_word_t out_word_q;

  // Stage 4 decision logic. The projection lies before the start when the
  // dot product is negative and beyond the end when it exceeds the squared
  // length; touching either end counts as interior.
  logic                 s4_degen, s4_beyond;
  logic signed [PW-1:0] s4_slack, s4_abs;
  logic [1:0]           s4_reg_d;
  logic [MW-1:0]        s4_num_d;

  always_comb begin
    s4_degen  = (s3_len2_q == '0);
    s4_slack  = s3_len2_q - s3_dot_q;
    s4_beyond = s4_slack[PW-1];
    s4_abs    = s3_cr_q[PW-1] ? -s3_cr_q : s3_cr_q;
    if (s4_degen) begin
      s4_reg_d = RegionDegenerate;
      s4_num_d = s3_wsq_q[MW-1:0];
    end else if (s3_dot_q[PW-1]) begin
      s4_reg_d = RegionStart;
      s4_num_d = s3_wsq_q[MW-1:0];
    end else if (s4_beyond) begin
      s4_reg_d = RegionEnd;
      s4_num_d = s3_esq_q[MW-1:0];
    end else begin
      s4_reg_d = RegionInterior;
      s4_num_d = s3_wsq_q[MW-1:0];
    end
  end

  // Dividend and divisor. For the interior the squared distance is
  // cross^2 / len2; elsewhere it is the squared end distance over one.
  logic [NW-1:0] div_num_d;
  logic [MW-1:0] div_den_d;

  always_comb begin
    if (s5_reg_q == RegionInterior) begin
      div_num_d = (NW'(s5_hh_q) << (2 * K)) + (NW'(s5_hl_q) << (K + 1)) + NW'(s5_ll_q);
      div_den_d = s5_den_q;
    end else begin
      div_num_d = NW'(s5_num_q);
      div_den_d = MW'(1);
    end
  end

  // Front stages.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_dx_q <= $signed({in_word_i.seg_end_x[CW-1], in_word_i.seg_end_x})
               - $signed({in_word_i.seg_start_x[CW-1], in_word_i.seg_start_x});
      s1_dy_q <= $signed({in_word_i.seg_end_y[CW-1], in_word_i.seg_end_y})
               - $signed({in_word_i.seg_start_y[CW-1], in_word_i.seg_start_y});
      s1_wx_q <= $signed({in_word_i.query_x[CW-1], in_word_i.query_x})
               - $signed({in_word_i.seg_start_x[CW-1], in_word_i.seg_start_x});
      s1_wy_q <= $signed({in_word_i.query_y[CW-1], in_word_i.query_y})
               - $signed({in_word_i.seg_start_y[CW-1], in_word_i.seg_start_y});
      s1_ex_q <= $signed({in_word_i.query_x[CW-1], in_word_i.query_x})
               - $signed({in_word_i.seg_end_x[CW-1], in_word_i.seg_end_x});
      s1_ey_q <= $signed({in_word_i.query_y[CW-1], in_word_i.query_y})
               - $signed({in_word_i.seg_end_y[CW-1], in_word_i.seg_end_y});

      s2_dxdx_q <= s1_dx_q * s1_dx_q;
      s2_dydy_q <= s1_dy_q * s1_dy_q;
      s2_wxdx_q <= s1_wx_q * s1_dx_q;
      s2_wydy_q <= s1_wy_q * s1_dy_q;
      s2_wxdy_q <= s1_wx_q * s1_dy_q;
      s2_wydx_q <= s1_wy_q * s1_dx_q;
      s2_wxwx_q <= s1_wx_q * s1_wx_q;
      s2_wywy_q <= s1_wy_q * s1_wy_q;
      s2_exex_q <= s1_ex_q * s1_ex_q;
      s2_eyey_q <= s1_ey_q * s1_ey_q;

      s3_len2_q <= s2_dxdx_q + s2_dydy_q;
      s3_dot_q  <= s2_wxdx_q + s2_wydy_q;
      s3_cr_q   <= s2_wxdy_q - s2_wydx_q;
      s3_wsq_q  <= s2_wxwx_q + s2_wywy_q;
      s3_esq_q  <= s2_exex_q + s2_eyey_q;

      s4_reg_q <= s4_reg_d;
      s4_num_q <= s4_num_d;
      s4_den_q <= s3_len2_q[MW-1:0];
      s4_mag_q <= s4_abs[MW-1:0];

      s5_reg_q <= s4_reg_q;
      s5_num_q <= s4_num_q;
      s5_den_q <= s4_den_q;
      s5_hh_q  <= (2*CW)'(s4_mag_q[MW-1:K]) * (2*CW)'(s4_mag_q[MW-1:K]);
      s5_hl_q  <= (2*CW+1)'(s4_mag_q[MW-1:K]) * (2*CW+1)'(s4_mag_q[K-1:0]);
      s5_ll_q  <= (2*CW+2)'(s4_mag_q[K-1:0]) * (2*CW+2)'(s4_mag_q[K-1:0]);

      div_rem_q[0] <= div_num_d[NW-1:MW];
      div_low_q[0] <= div_num_d[MW-1:0];
      div_den_q[0] <= div_den_d;
      div_reg_q[0] <= s5_reg_q;

      out_word_q.distance       <= sq_root_q[SW];
      out_word_q.nearest_region <= sq_reg_q[SW];
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < MW; k++) begin : g_div
    logic [MW:0] trial;
    logic        fits;
    assign trial = {div_rem_q[k], div_low_q[k][MW-1]};
    assign fits  = (trial >= {1'b0, div_den_q[k]});
    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        div_rem_q[k+1] <= fits ? MW'(trial - {1'b0, div_den_q[k]}) : trial[MW-1:0];
        div_low_q[k+1] <= {div_low_q[k][MW-2:0], fits};
        div_den_q[k+1] <= div_den_q[k];
        div_reg_q[k+1] <= div_reg_q[k];
      end
    end
  end

  // Digit by digit integer square root of the quotient, two radicand bits in
  // and one root bit out per stage.
  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [SW+2:0] part, trial;
    logic          fits;
    if (k == 0) begin : g_first
      assign sq_rem_in[k]  = '0;
      assign sq_root_in[k] = '0;
      assign sq_x_in[k]    = {1'b0, div_low_q[MW]};
      assign sq_reg_in[k]  = div_reg_q[MW];
    end else begin : g_next
      assign sq_rem_in[k]  = sq_rem_q[k];
      assign sq_root_in[k] = sq_root_q[k];
      assign sq_x_in[k]    = sq_x_q[k];
      assign sq_reg_in[k]  = sq_reg_q[k];
    end
    assign part  = {sq_rem_in[k], sq_x_in[k][2*SW-1 -: 2]};
    assign trial = {1'b0, sq_root_in[k], 2'b01};
    assign fits  = (part >= trial);
    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        sq_rem_q[k+1]  <= fits ? (SW+1)'(part - trial) : part[SW:0];
        sq_root_q[k+1] <= {sq_root_in[k][SW-2:0], fits};
        sq_x_q[k+1]    <= {sq_x_in[k][2*SW-3:0], 2'b00};
        sq_reg_q[k+1]  <= sq_reg_in[k];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      div_v_q     <= '0;
      sq_v_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s1_v_q      <= in_valid_i;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      s5_v_q      <= s4_v_q;
      div_v_q     <= {div_v_q[MW-1:0], s5_v_q};
      sq_v_q      <= {sq_v_q[SW-1:1], div_v_q[MW]};
      out_valid_q <= sq_v_q[SW];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // A divisor of zero would mean the degenerate case slipped into the
  // interior path.
  `PSD_ASSERT_SAME(a_div_den_nonzero, div_v_q[0], div_den_q[0] != '0,
    "divider entered with a zero divisor")
  `PSD_ASSERT_SAME(a_div_rem_below_den, div_v_q[MW], div_rem_q[MW] < div_den_q[MW],
    "division remainder not below the divisor")
  `PSD_ASSERT_SAME(a_sqrt_rem_bound, sq_v_q[SW], sq_rem_q[SW] <= {sq_root_q[SW], 1'b0},
    "square root remainder exceeds twice the root")
  `PSD_ASSERT_NEXT(a_out_drains, out_valid_q && !out_stall_i && !sq_v_q[SW], !out_valid_q,
    "output word repeated after delivery")

endmodule

`default_nettype wire

// ----- test/psd_checker.sv -----
// ----------------------------------------------------------------------------
// psd_checker
// Watches both channels of the distance unit, predicts each result exactly
// with wide integer arithmetic and compares it, in order, with what arrives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psd_checker
  import psd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_stall_i,
  input  wire in_word_t  in_word_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_stall_i,
  input  wire out_word_t out_word_i,
  output int             fail_count_o,
  output int             pending_count_o
);

  typedef logic signed [255:0] wide_t;

  out_word_t expected_distances[$];

  // Exact projection test and floor square root on integers wide enough
  // that nothing overflows.
  function automatic out_word_t nearest_distance(in_word_t w);
    wide_t ax, ay, bx, by, px, py;
    wide_t dx, dy, wx, wy, len2, dot, num, den, cr, cand, root;
    out_word_t r;
    ax = w.seg_start_x;
    ay = w.seg_start_y;
    bx = w.seg_end_x;
    by = w.seg_end_y;
    px = w.query_x;
    py = w.query_y;
    dx = bx - ax;
    dy = by - ay;
    wx = px - ax;
    wy = py - ay;
    len2 = dx * dx + dy * dy;
    den = 1;
    if (len2 == 0) begin
      r.nearest_region = RegionDegenerate;
      num = wx * wx + wy * wy;
    end else begin
      dot = wx * dx + wy * dy;
      if (dot < 0) begin
        r.nearest_region = RegionStart;
        num = wx * wx + wy * wy;
      end else if (dot > len2) begin
        r.nearest_region = RegionEnd;
        num = (px - bx) * (px - bx) + (py - by) * (py - by);
      end else begin
        r.nearest_region = RegionInterior;
        cr = wx * dy - wy * dx;
        num = cr * cr;
        den = len2;
      end
    end
    root = 0;
    for (int b = DistWidth; b >= 0; b--) begin
      cand = root | (wide_t'(1) << b);
      if (cand * cand * den <= num) root = cand;
    end
    r.distance = root[DistWidth-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      fail_count_o    <= 0;
      pending_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_distances = {expected_distances, nearest_distance(in_word_i)};
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_distances.size() == 0) begin
          $display("%0t: unexpected word, distance %0d region %0d", $time,
                   out_word_i.distance, out_word_i.nearest_region);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = expected_distances.pop_front();
          if (exp_w.distance !== out_word_i.distance) begin
            $display("%0t: distance expected %0d actual %0d", $time,
                     exp_w.distance, out_word_i.distance);
            fail_count_o <= fail_count_o + 1;
          end else if (exp_w.nearest_region !== out_word_i.nearest_region) begin
            $display("%0t: region expected %0d actual %0d", $time,
                     exp_w.nearest_region, out_word_i.nearest_region);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_count_o <= expected_distances.size();
    end
  end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives directed and random segment queries into the distance unit under
// random idling on both sides; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import psd_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int MaxCoord   = 32'h7fffffff;
  localparam int MinCoord   = 32'h80000000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;
  int        fail_count;
  int        pending_count;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // A period of 20 ns.
  always #10 clk_i = ~clk_i;

  point_segment_distance_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o)
  );

  psd_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_i(in_stall_o), .in_word_i(in_word_i),
    .out_valid_i(out_valid_o), .out_stall_i(out_stall_i), .out_word_i(out_word_o),
    .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  // The sink stalls at random, changing only at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // A watchdog: a hung pipeline must not run for ever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("point_segment_distance_unit: mismatch");
      $finish;
    end
  end

  // Offers one word, idling first at random, and holds it until it is taken.
  // Called and returning at a falling edge, so valid is never lowered and
  // raised again within one time step.
  task automatic send_query(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_points(int ax, int ay, int bx, int by, int px, int py);
    in_word_t w;
    w.seg_start_x = ax;
    w.seg_start_y = ay;
    w.seg_end_x   = bx;
    w.seg_end_y   = by;
    w.query_x     = px;
    w.query_y     = py;
    send_query(w);
  endtask

  // Full-range values half the time, else a small neighbourhood or an extreme,
  // so that every region turns up often.
  function automatic int random_coord();
    case ($urandom_range(3))
      0:       return $urandom_range(65536 * 8) - 65536 * 4;
      1:       return ($urandom_range(1)) ? MaxCoord - $urandom_range(3)
                                          : MinCoord + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    int ax, ay, bx, by, px, py, k;
    bit at_end;
    ax = random_coord();
    ay = random_coord();
    bx = random_coord();
    by = random_coord();
    px = random_coord();
    py = random_coord();
    k = $urandom_range(19);
    // Degenerate segments, a point on one of the ends, and a point whose
    // projection lands exactly on an end, each a few percent of the time.
    if (k == 0) begin
      bx = ax;
      by = ay;
    end else if (k == 1) begin
      px = ax;
      py = ay;
    end else if (k == 2) begin
      px = bx;
      py = by;
    end else if (k == 3) begin
      ax = $urandom_range(2000) - 1000;
      ay = $urandom_range(2000) - 1000;
      bx = ax + $urandom_range(200) - 100;
      by = ay + $urandom_range(200) - 100;
      k  = $urandom_range(400) - 200;
      at_end = $urandom_range(1);
      // Perpendicular to the segment through the start or the end.
      px = (at_end ? bx : ax) - k * (by - ay);
      py = (at_end ? by : ay) + k * (bx - ax);
    end
    send_points(ax, ay, bx, by, px, py);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct  = 6;
    recv_stall_pct = 72;

    // Directed words: the extremes, every region and the boundary cases.
    send_points(MinCoord, MinCoord, MinCoord, MinCoord, MinCoord, MinCoord);
    send_points(MaxCoord, MaxCoord, MaxCoord, MaxCoord, MaxCoord, MaxCoord);
    send_points(MinCoord, MinCoord, MinCoord, MinCoord, MaxCoord, MaxCoord);
    send_points(MinCoord, MaxCoord, MaxCoord, MinCoord, MaxCoord, MaxCoord);
    send_points(MinCoord, MinCoord, MaxCoord, MaxCoord, MinCoord, MaxCoord);
    send_points(MinCoord, MinCoord, MinCoord, MinCoord + 1, MaxCoord, MaxCoord);
    send_points(0, 0, 0, 0, 0, 0);
    send_points(0, 0, 0, 0, 3 << 16, 4 << 16);
    send_points(0, 0, 10 << 16, 0, -(3 << 16), 4 << 16);
    send_points(0, 0, 10 << 16, 0, 13 << 16, 4 << 16);
    send_points(0, 0, 10 << 16, 0, 5 << 16, 4 << 16);
    send_points(0, 0, 10 << 16, 0, 0, 7 << 16);
    send_points(0, 0, 10 << 16, 0, 10 << 16, -(7 << 16));
    send_points(0, 0, 10 << 16, 0, 5 << 16, 0);
    send_points(1, 1, 4, 5, 1, 1);
    send_points(1, 1, 4, 5, 4, 5);
    send_points(0, 0, 1, 0, 0, 1);
    send_points(0, 0, 3, 3, 1, 0);
    send_points(-1, -1, -1, -1, 0, 0);
    send_points(MaxCoord, 0, MinCoord, 0, 0, MaxCoord);
    send_points(0, MinCoord, 0, MaxCoord, MinCoord, 0);
    send_points(MaxCoord, MaxCoord, MinCoord, MinCoord, MaxCoord, MinCoord);

    repeat (360) send_random();
    send_idle_pct  = 72;
    recv_stall_pct = 6;
    repeat (385) send_random();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (385) send_random();
    in_valid_i <= 1'b0;

    // Drain the pipeline, then allow its full latency for anything stray.
    while (pending_count != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("point_segment_distance_unit: match");
    end else begin
      $display("point_segment_distance_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
